FILE: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

FILE: design/tpfr_pkg.sv
// shared types, codes and defaults for the two-level priority ring fifo
// no dependencies; imported by every module of the block
package tpfr_pkg;

    // fixed port widths
    localparam int CAP_BITS  = 5;
    localparam int DATA_BITS = 32;

    // defaults handed to the top level
    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_WORD_BITS = 32;

    // capacity after reset
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_PUSH_ANY = 2'd2;
    localparam logic [1:0] OP_POP_ANY  = 2'd3;

    // queue select
    localparam logic QUEUE_HIGH = 1'b1;
    localparam logic QUEUE_LOW  = 1'b0;

    // control of one request travelling down the cell chain
    typedef struct packed {
        logic valid;
        logic write;
        logic read;
        logic queue;
    } req_ctrl_t;

endpackage

FILE: design/tpfr_head.sv
// request decode, pointers, fill counts and capacity register
// depends on tpfr_pkg; feeds the first cell of the chain
module tpfr_head
    import tpfr_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int WORD_BITS = DEFAULT_WORD_BITS,
    parameter int PTR_BITS  = 4,
    parameter int CNT_BITS  = 5,
    parameter int TOT_BITS  = 6,
    parameter int CMP_BITS  = 5
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [1:0]                        op,
    input  logic                              priority_req,
    input  logic signed [DATA_BITS-1:0]       data_in,
    input  logic                              cfg_we,
    input  logic [CAP_BITS-1:0]               cfg_data,
    output req_ctrl_t                         ctrl_reg,
    output logic [PTR_BITS-1:0]               slot_reg,
    output logic [WORD_BITS-1:0]              word_reg,
    output logic [2*CNT_BITS+TOT_BITS-1:0]    stat
);

    logic [CAP_BITS-1:0] capacity_reg;
    logic [CNT_BITS-1:0] high_fill_reg, high_fill_next;
    logic [CNT_BITS-1:0] low_fill_reg, low_fill_next;
    logic [PTR_BITS-1:0] high_wr_reg, high_wr_next, high_rd_reg, high_rd_next;
    logic [PTR_BITS-1:0] low_wr_reg, low_wr_next, low_rd_reg, low_rd_next;
    logic [CMP_BITS-1:0] cap_ext, eff_cap;
    logic                high_room, low_room, high_any, low_any;
    logic                do_write, do_read, sel_q;
    logic [PTR_BITS-1:0] slot;
    logic [WORD_BITS+DATA_BITS-1:0] word_wide;

    // pointer advance with wrap at the effective capacity
    function automatic logic [PTR_BITS-1:0] bump(
        input logic [PTR_BITS-1:0] ptr,
        input logic [CMP_BITS-1:0] lim
    );
        logic [CMP_BITS-1:0] nxt;
        nxt = CMP_BITS'(ptr) + CMP_BITS'(1);
        return (nxt >= lim) ? '0 : nxt[PTR_BITS-1:0];
    endfunction

    // capacity saturates at the built depth
    assign cap_ext = CMP_BITS'(capacity_reg);
    assign eff_cap = (cap_ext > CMP_BITS'(DEPTH)) ? CMP_BITS'(DEPTH) : cap_ext;

    // full and empty flags
    assign high_room = CMP_BITS'(high_fill_reg) < eff_cap;
    assign low_room  = CMP_BITS'(low_fill_reg) < eff_cap;
    assign high_any  = high_fill_reg != '0;
    assign low_any   = low_fill_reg != '0;

    // pick queue and direction
    always_comb
    begin
        do_write = 1'b0;
        do_read  = 1'b0;
        sel_q    = priority_req;
        case (op)
            OP_PUSH:
            begin
                do_write = priority_req ? high_room : low_room;
            end
            OP_POP:
            begin
                do_read = priority_req ? high_any : low_any;
            end
            OP_PUSH_ANY:
            begin
                sel_q    = high_room ? QUEUE_HIGH : QUEUE_LOW;
                do_write = high_room || low_room;
            end
            default:
            begin
                sel_q   = high_any ? QUEUE_HIGH : QUEUE_LOW;
                do_read = high_any || low_any;
            end
        endcase
    end

    // slot addressed by the request
    always_comb
    begin
        if (sel_q == QUEUE_HIGH)
        begin
            slot = do_write ? high_wr_reg : high_rd_reg;
        end
        else
        begin
            slot = do_write ? low_wr_reg : low_rd_reg;
        end
    end

    // pointer and count updates
    always_comb
    begin
        high_fill_next = high_fill_reg;
        low_fill_next  = low_fill_reg;
        high_wr_next   = high_wr_reg;
        high_rd_next   = high_rd_reg;
        low_wr_next    = low_wr_reg;
        low_rd_next    = low_rd_reg;
        if (accept && do_write)
        begin
            if (sel_q == QUEUE_HIGH)
            begin
                high_wr_next   = bump(high_wr_reg, eff_cap);
                high_fill_next = high_fill_reg + CNT_BITS'(1);
            end
            else
            begin
                low_wr_next   = bump(low_wr_reg, eff_cap);
                low_fill_next = low_fill_reg + CNT_BITS'(1);
            end
        end
        if (accept && do_read)
        begin
            if (sel_q == QUEUE_HIGH)
            begin
                high_rd_next   = bump(high_rd_reg, eff_cap);
                high_fill_next = high_fill_reg - CNT_BITS'(1);
            end
            else
            begin
                low_rd_next   = bump(low_rd_reg, eff_cap);
                low_fill_next = low_fill_reg - CNT_BITS'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            high_fill_reg <= '0;
            low_fill_reg  <= '0;
            high_wr_reg   <= '0;
            high_rd_reg   <= '0;
            low_wr_reg    <= '0;
            low_rd_reg    <= '0;
            ctrl_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            high_fill_reg  <= high_fill_next;
            low_fill_reg   <= low_fill_next;
            high_wr_reg    <= high_wr_next;
            high_rd_reg    <= high_rd_next;
            low_wr_reg     <= low_wr_next;
            low_rd_reg     <= low_rd_next;
            ctrl_reg.valid <= accept;
            ctrl_reg.write <= accept && do_write;
            ctrl_reg.read  <= accept && do_read;
            ctrl_reg.queue <= sel_q;
        end
    end

    // word fitted to the stored width
    assign word_wide = {{WORD_BITS{1'b0}}, data_in};

    // request payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot;
        word_reg <= word_wide[WORD_BITS-1:0];
    end

    // counts after the step, read while the request sits at the first cell
    assign stat = {high_fill_reg, low_fill_reg,
                   TOT_BITS'(high_fill_reg) + TOT_BITS'(low_fill_reg)};

endmodule

FILE: design/tpfr_cell.sv
// one storage slot of both queues, acting on requests that pass by
// depends on tpfr_pkg; instantiated once per slot by the top level
module tpfr_cell
    import tpfr_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int WORD_BITS = DEFAULT_WORD_BITS,
    parameter int PTR_BITS  = 4,
    parameter int STAT_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  req_ctrl_t            ctrl_in,
    input  logic [PTR_BITS-1:0]  slot_in,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [WORD_BITS-1:0] rd_in,
    input  logic [STAT_BITS-1:0] stat_in,
    output req_ctrl_t            ctrl_reg,
    output logic [PTR_BITS-1:0]  slot_reg,
    output logic [WORD_BITS-1:0] word_reg,
    output logic [WORD_BITS-1:0] rd_reg,
    output logic [STAT_BITS-1:0] stat_reg
);

    logic [WORD_BITS-1:0] high_word_reg;
    logic [WORD_BITS-1:0] low_word_reg;
    logic                 hit;
    logic [WORD_BITS-1:0] rd_next;

    assign hit = ctrl_in.valid && (slot_in == PTR_BITS'(INDEX));

    // stored words, written when a push addresses this slot
    always_ff @(posedge clk)
    begin
        if (hit && ctrl_in.write)
        begin
            if (ctrl_in.queue == QUEUE_HIGH)
            begin
                high_word_reg <= word_in;
            end
            else
            begin
                low_word_reg <= word_in;
            end
        end
    end

    // pop of this slot places its word on the read lane
    always_comb
    begin
        rd_next = rd_in;
        if (hit && ctrl_in.read)
        begin
            rd_next = (ctrl_in.queue == QUEUE_HIGH) ? high_word_reg : low_word_reg;
        end
    end

    // hand the request to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_in;
        word_reg <= word_in;
        rd_reg   <= rd_next;
        stat_reg <= stat_in;
    end

endmodule

FILE: design/two_level_priority_ring_fifo.sv
// top level: request head followed by one cell per storage slot
// depends on tpfr_pkg, tpfr_head and tpfr_cell
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------
//  request   | start, busy         | op, priority_req, data_in
//  result    | done (one cycle)    | ok, data_out, high_count, low_count,
//            |                     | total_count
//  config    | cfg_we              | cfg_data (capacity)
//
// a request is taken every cycle; busy stays low
// done rises once the accepting edge has loaded the head register and the
// request has passed every cell register in turn; the result is taken at the
// edge after done rises
// results leave in request order and cannot be held off by the receiver
// reset clears pointers, counts and the request control of the chain and sets
// capacity to 16; stored words and payload registers are not cleared
module two_level_priority_ring_fifo
    import tpfr_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        op,
    input  logic                              priority_req,
    input  logic signed [DATA_BITS-1:0]       data_in,
    input  logic                              cfg_we,
    input  logic [CAP_BITS-1:0]               cfg_data,
    output logic                              done,
    output logic                              ok,
    output logic signed [DATA_BITS-1:0]       data_out,
    output logic [$clog2(DEPTH+1)-1:0]        high_count,
    output logic [$clog2(DEPTH+1)-1:0]        low_count,
    output logic [$clog2(2*DEPTH+1)-1:0]      total_count
);

    localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(DEPTH+1);
    localparam int TOT_BITS  = $clog2(2*DEPTH+1);
    localparam int CMP_BITS  = (CAP_BITS > PTR_BITS + 1) ? CAP_BITS : PTR_BITS + 1;
    localparam int STAT_BITS = 2*CNT_BITS + TOT_BITS;

    logic                   accept;
    req_ctrl_t              stage_ctrl [0:DEPTH];
    logic [PTR_BITS-1:0]    stage_slot [0:DEPTH];
    logic [WORD_BITS-1:0]   stage_word [0:DEPTH];
    logic [WORD_BITS-1:0]   stage_rd   [0:DEPTH];
    logic [STAT_BITS-1:0]   stage_stat [0:DEPTH];
    logic [WORD_BITS+DATA_BITS-1:0] rd_wide;

    // the chain takes a new request every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // decode and pointer bookkeeping
    tpfr_head #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .PTR_BITS  (PTR_BITS),
        .CNT_BITS  (CNT_BITS),
        .TOT_BITS  (TOT_BITS),
        .CMP_BITS  (CMP_BITS)
    ) u_head (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .op           (op),
        .priority_req (priority_req),
        .data_in      (data_in),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .ctrl_reg     (stage_ctrl[0]),
        .slot_reg     (stage_slot[0]),
        .word_reg     (stage_word[0]),
        .stat         (stage_stat[0])
    );

    // read lane starts empty
    assign stage_rd[0] = '0;

    // one cell per slot
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tpfr_cell #(
            .INDEX     (i),
            .WORD_BITS (WORD_BITS),
            .PTR_BITS  (PTR_BITS),
            .STAT_BITS (STAT_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (stage_ctrl[i]),
            .slot_in  (stage_slot[i]),
            .word_in  (stage_word[i]),
            .rd_in    (stage_rd[i]),
            .stat_in  (stage_stat[i]),
            .ctrl_reg (stage_ctrl[i+1]),
            .slot_reg (stage_slot[i+1]),
            .word_reg (stage_word[i+1]),
            .rd_reg   (stage_rd[i+1]),
            .stat_reg (stage_stat[i+1])
        );
    end

    // result from the end of the chain
    assign rd_wide     = {{DATA_BITS{1'b0}}, stage_rd[DEPTH]};
    assign done        = stage_ctrl[DEPTH].valid;
    assign ok          = stage_ctrl[DEPTH].write || stage_ctrl[DEPTH].read;
    assign data_out    = rd_wide[DATA_BITS-1:0];
    assign high_count  = stage_stat[DEPTH][STAT_BITS-1 -: CNT_BITS];
    assign low_count   = stage_stat[DEPTH][TOT_BITS +: CNT_BITS];
    assign total_count = stage_stat[DEPTH][TOT_BITS-1:0];

endmodule

FILE: design/tpfr_checker.sv
// port-level checks on the two-level priority ring fifo
// depends on tpfr_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module tpfr_checker
    import tpfr_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic                          ok,
    input logic signed [DATA_BITS-1:0]   data_out,
    input logic [$clog2(DEPTH+1)-1:0]    high_count,
    input logic [$clog2(DEPTH+1)-1:0]    low_count,
    input logic [$clog2(2*DEPTH+1)-1:0]  total_count
);

    localparam int CNT_BITS = $clog2(DEPTH+1);
    localparam int TOT_BITS = $clog2(2*DEPTH+1);

    // every result comes from an accepted request that has passed the head and every cell
    `ASSERT_IMPLY(a_done_latency, clk, rst_n, done, $past(start && !busy, DEPTH+1), "result without request")

    // total matches the two queue counts
    `ASSERT_IMPLY(a_total_sum, clk, rst_n, done, total_count == TOT_BITS'(high_count) + TOT_BITS'(low_count), "total count mismatch")

    // back-to-back results change the total exactly when the later one succeeds
    `ASSERT_IMPLY(a_total_step, clk, rst_n, done && $past(done), (ok && total_count != $past(total_count)) || (!ok && total_count == $past(total_count)), "total count step wrong")

    // failed request returns no word, counts stay within the depth
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, done && !ok, data_out == '0, "failed request returned data")
    `ASSERT_HOLDS(a_count_bound, clk, rst_n, !done || (high_count <= CNT_BITS'(DEPTH) && low_count <= CNT_BITS'(DEPTH)), "count above depth")

endmodule

bind two_level_priority_ring_fifo tpfr_checker #(.DEPTH(DEPTH)) u_tpfr_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for two_level_priority_ring_fifo: directed and random requests over several
// capacity settings, every result checked in order against a predictor of both rings
// depends on tpfr_pkg and the two_level_priority_ring_fifo top level
module tb_top;
    import tpfr_pkg::*;

    localparam int DEPTH          = DEFAULT_DEPTH;
    localparam int CNT_BITS       = $clog2(DEPTH + 1);
    localparam int TOT_BITS       = $clog2(2 * DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SEGMENT_ITEMS  = 160;

    // one predicted result
    typedef struct {
        logic                 ok;
        logic [DATA_BITS-1:0] word;
        logic [CNT_BITS-1:0]  high_cnt;
        logic [CNT_BITS-1:0]  low_cnt;
        logic [TOT_BITS-1:0]  total_cnt;
    } fifo_result_t;

    // predicts both rings and checks results in request order
    class ring_pair_scoreboard;
        logic [DATA_BITS-1:0] store [2][DEPTH];
        bit                   written [2][DEPTH];
        int unsigned          fill [2];
        int unsigned          wr_ptr [2];
        int unsigned          rd_ptr [2];
        int unsigned          capacity;
        fifo_result_t         expected_results [$];
        int unsigned          failures;
        int unsigned          checked;
        int unsigned          good_pushes;
        int unsigned          good_pops;
        int unsigned          refused;

        function new();
            capacity = CAP_RESET;
            for (int q = 0; q < 2; q++)
            begin
                fill[q]   = 0;
                wr_ptr[q] = 0;
                rd_ptr[q] = 0;
                for (int i = 0; i < DEPTH; i++)
                begin
                    store[q][i]   = '0;
                    written[q][i] = 1'b0;
                end
            end
            failures    = 0;
            checked     = 0;
            good_pushes = 0;
            good_pops   = 0;
            refused     = 0;
        endfunction

        // capacity above the built depth saturates
        function int unsigned usable_slots();
            return (capacity > DEPTH) ? DEPTH : capacity;
        endfunction

        // pointer wraps once its increment reaches the usable size
        function int unsigned advance(int unsigned ptr);
            return (ptr + 1 >= usable_slots()) ? 0 : ptr + 1;
        endfunction

        function bit fully_written(int q);
            for (int i = 0; i < DEPTH; i++)
                if (!written[q][i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function bit try_push(logic q, logic [DATA_BITS-1:0] word);
            if (fill[q] >= usable_slots())
                return 1'b0;
            store[q][wr_ptr[q] % DEPTH]   = word;
            written[q][wr_ptr[q] % DEPTH] = 1'b1;
            wr_ptr[q] = advance(wr_ptr[q]);
            fill[q]++;
            return 1'b1;
        endfunction

        function bit try_pop(logic q, output logic [DATA_BITS-1:0] word);
            word = '0;
            if (fill[q] == 0)
                return 1'b0;
            word = store[q][rd_ptr[q] % DEPTH];
            rd_ptr[q] = advance(rd_ptr[q]);
            fill[q]--;
            return 1'b1;
        endfunction

        // accepted request: update the rings and queue the result it must give
        function void note_request(logic [1:0] req_op, logic req_queue,
                                   logic [DATA_BITS-1:0] word);
            fifo_result_t         res;
            logic [DATA_BITS-1:0] popped;
            bit                   success;
            popped  = '0;
            success = 1'b0;
            case (req_op)
                OP_PUSH:
                    success = try_push(req_queue, word);
                OP_POP:
                    success = try_pop(req_queue, popped);
                OP_PUSH_ANY:
                begin
                    success = try_push(QUEUE_HIGH, word);
                    if (!success)
                        success = try_push(QUEUE_LOW, word);
                end
                OP_POP_ANY:
                begin
                    success = try_pop(QUEUE_HIGH, popped);
                    if (!success)
                        success = try_pop(QUEUE_LOW, popped);
                end
            endcase
            if (!success)
            begin
                popped = '0;
                refused++;
            end
            else if (req_op == OP_PUSH || req_op == OP_PUSH_ANY)
                good_pushes++;
            else
                good_pops++;
            res.ok        = success;
            res.word      = popped;
            res.high_cnt  = CNT_BITS'(fill[QUEUE_HIGH]);
            res.low_cnt   = CNT_BITS'(fill[QUEUE_LOW]);
            res.total_cnt = TOT_BITS'(fill[QUEUE_HIGH] + fill[QUEUE_LOW]);
            expected_results.push_back(res);
        endfunction

        // compare one strobed result with the oldest prediction
        function void check_result(logic got_ok, logic [DATA_BITS-1:0] got_word,
                                   logic [CNT_BITS-1:0] got_high, logic [CNT_BITS-1:0] got_low,
                                   logic [TOT_BITS-1:0] got_total);
            fifo_result_t want;
            checked++;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result with no request waiting: ok=%0b data=%h high=%0d low=%0d total=%0d",
                             got_ok, got_word, got_high, got_low, got_total);
                return;
            end
            want = expected_results.pop_front();
            if (want.ok !== got_ok || want.word !== got_word || want.high_cnt !== got_high ||
                want.low_cnt !== got_low || want.total_cnt !== got_total)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch on result %0d: expected ok=%0b data=%h high=%0d low=%0d total=%0d, got ok=%0b data=%h high=%0d low=%0d total=%0d",
                             checked, want.ok, want.word, want.high_cnt, want.low_cnt,
                             want.total_cnt, got_ok, got_word, got_high, got_low, got_total);
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  op;
    logic                        priority_req;
    logic signed [DATA_BITS-1:0] data_in;
    logic                        cfg_we;
    logic [CAP_BITS-1:0]         cfg_data;
    logic                        done;
    logic                        ok;
    logic signed [DATA_BITS-1:0] data_out;
    logic [CNT_BITS-1:0]         high_count;
    logic [CNT_BITS-1:0]         low_count;
    logic [TOT_BITS-1:0]         total_count;

    ring_pair_scoreboard sb = new();
    int unsigned         idle_pct = 0;
    int unsigned         requests_sent = 0;
    int unsigned         settings_used = 0;
    int unsigned         quiet_cycles = 0;
    logic [CAP_BITS-1:0] segment_caps [8] = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd9, 5'd17, 5'd16};

    two_level_priority_ring_fifo #(
        .DEPTH     (DEPTH),
        .WORD_BITS (DEFAULT_WORD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .priority_req (priority_req),
        .data_in      (data_in),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .ok           (ok),
        .data_out     (data_out),
        .high_count   (high_count),
        .low_count    (low_count),
        .total_count  (total_count)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(ok, data_out, high_count, low_count, total_count);
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no activity for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // word mix with the extremes over-weighted
    function automatic logic [DATA_BITS-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return 32'h7fff_ffff;
            2: return 32'h8000_0000;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    // one request, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] req_op, input logic req_queue,
                                input logic [DATA_BITS-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        op           <= req_op;
        priority_req <= req_queue;
        data_in      <= word;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_request(req_op, req_queue, word);
        requests_sent++;
    endtask

    // sender quiet until every expected result has come back
    task automatic wait_all_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // capacity write with the block idle
    task automatic change_capacity(input logic [CAP_BITS-1:0] value);
        wait_all_results();
        // a ring with slots never written is emptied first so no stale slot gets popped
        for (int q = 0; q < 2; q++)
        begin
            if (!sb.fully_written(q))
                while (sb.fill[q] != 0)
                    send_request(OP_POP, q[0], $urandom());
        end
        wait_all_results();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        sb.capacity = value;
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random requests in bursts that lean to pushes, to pops, or neither
    task automatic run_segment(input int unsigned count, input bit fill_first);
        int unsigned burst_left;
        int unsigned push_pct;
        logic [1:0]  req_op;
        burst_left = 0;
        push_pct   = 50;
        if (fill_first)
        begin
            burst_left = 48;
            push_pct   = 85;
        end
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 6);
                case ($urandom_range(2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            burst_left--;
            if ($urandom_range(99) < push_pct)
                req_op = $urandom_range(1) ? OP_PUSH : OP_PUSH_ANY;
            else
                req_op = $urandom_range(1) ? OP_POP : OP_POP_ANY;
            send_request(req_op, 1'($urandom_range(1)), pick_word());
        end
    endtask

    // stimulus
    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        op           <= OP_PUSH;
        priority_req <= QUEUE_LOW;
        data_in      <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= CAP_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty rings, extremes, priority order of the fallback ops
        send_request(OP_POP, QUEUE_HIGH, 32'h1234_5678);
        send_request(OP_POP, QUEUE_LOW, '0);
        send_request(OP_POP_ANY, QUEUE_HIGH, '1);
        send_request(OP_PUSH, QUEUE_HIGH, 32'h7fff_ffff);
        send_request(OP_PUSH, QUEUE_LOW, 32'h8000_0000);
        send_request(OP_PUSH_ANY, QUEUE_LOW, '1);
        send_request(OP_PUSH, QUEUE_LOW, '0);
        send_request(OP_POP_ANY, QUEUE_LOW, '0);
        send_request(OP_POP, QUEUE_LOW, '0);
        send_request(OP_POP_ANY, QUEUE_HIGH, '0);
        send_request(OP_POP_ANY, QUEUE_HIGH, '0);
        send_request(OP_POP_ANY, QUEUE_LOW, '0);

        // single slot: fallback push spills to the low ring, then both full
        change_capacity(5'd1);
        send_request(OP_PUSH_ANY, QUEUE_LOW, 32'ha5a5_a5a5);
        send_request(OP_PUSH_ANY, QUEUE_HIGH, 32'h5a5a_5a5a);
        send_request(OP_PUSH_ANY, QUEUE_LOW, 32'h0000_0001);
        send_request(OP_PUSH, QUEUE_HIGH, 32'h0000_0002);
        send_request(OP_POP_ANY, QUEUE_LOW, '0);
        send_request(OP_POP_ANY, QUEUE_HIGH, '0);

        // zero capacity refuses every push
        change_capacity(5'd0);
        send_request(OP_PUSH, QUEUE_HIGH, 32'h0000_0003);
        send_request(OP_PUSH_ANY, QUEUE_LOW, 32'hffff_fffe);
        send_request(OP_POP, QUEUE_LOW, '0);

        // oversized capacity saturates to the built depth
        change_capacity(5'd31);
        send_request(OP_PUSH, QUEUE_HIGH, 32'h1234_5678);
        send_request(OP_POP, QUEUE_HIGH, '0);

        // random segments; capacity changes may land on rings holding data
        for (int s = 0; s < 8; s++)
        begin
            change_capacity(segment_caps[s]);
            idle_pct = (s < 3) ? 35 : ((s < 6) ? 45 : 0);
            run_segment(SEGMENT_ITEMS, s == 0);
        end

        wait_all_results();
        repeat (DEPTH + 4) @(posedge clk);

        $display("run covered %0d requests over %0d capacity settings: %0d pushes taken, %0d pops served, %0d refused",
                 requests_sent, settings_used, sb.good_pushes, sb.good_pops, sb.refused);
        $display("%0d results checked, %0d mismatches, %0d still outstanding",
                 sb.checked, sb.failures, sb.pending());
        if (sb.failures == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: two_level_priority_ring_fifo.f
+incdir+design
design/tpfr_pkg.sv
design/tpfr_head.sv
design/tpfr_cell.sv
design/two_level_priority_ring_fifo.sv
design/tpfr_checker.sv
tb/tb_top.sv
